### sv/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared codes and controller/datapath interface types for the slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int BSIZE_W  = 17;
    localparam int SLOT_O_W = 8;
    localparam int OFF_W    = 24;
    localparam int IN_ID_W  = 64;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd4096;

    localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EVICT    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;     // capture request, reset the scan
        logic scan_run;  // issue owner reads and compare
        logic exec;      // decide status, update stack and owner store
        logic mul;       // form the byte offset
        logic load_out;  // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic out_full;
    } t_sts;

endpackage : bsa_pkg
`default_nettype wire

### sv/block_slot_allocator_index.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_slot_allocator_index
// Slot allocator with block id index for a slot-based block store.
// ----------------------------------------------------------------------------
// One request at a time. Each request scans the owner store one entry per
// cycle over the slots handed out so far (at most CAPACITY). It then executes,
// forms slot times the block size and loads the output register, in the
// states EXEC, MUL and LOAD. The scan covers every distinct slot allocated
// since reset, read through the single read port of the owner store.
// The next transfer can be taken in the same cycle as the result appears.
// A lookup stops early at the first matching slot. The finished result sits
// in an output register, and the next request is taken while it waits. That
// request then holds in its load step until the waiting result is taken. No
// clearing pass follows reset: slots never allocated are known to be empty,
// and free-stack entries never written are derived from their position.
// Write the block size register only while no request is in flight.
// ----------------------------------------------------------------------------
module block_slot_allocator_index
    import bsa_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int ID_BITS  = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire [MODE_W-1:0]    i_mode,
    input  wire [IN_ID_W-1:0]   i_block_id,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [SLOT_O_W-1:0] o_slot,
    output logic [OFF_W-1:0]    o_byte_offset,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [BSIZE_W-1:0]   i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bsa_datapath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (i_mode),
        .i_block_id    (i_block_id),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_slot        (o_slot),
        .o_byte_offset (o_byte_offset)
    );

endmodule : block_slot_allocator_index
`default_nettype wire

### sv/bsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: accept, scan the owner store, execute, multiply, deliver.
// ----------------------------------------------------------------------------
module bsa_ctrl
    import bsa_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EXEC = 5'b00100,
        S_MUL  = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                // hold until the previous result has been taken
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule : bsa_ctrl
`default_nettype wire

### sv/bsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_datapath
// Free stack, owner store with scan pipeline, offset multiplier, output register.
// ----------------------------------------------------------------------------
module bsa_datapath
    import bsa_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int ID_BITS  = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  wire [MODE_W-1:0]     i_mode,
    input  wire [IN_ID_W-1:0]    i_block_id,
    input  wire                  i_cfg_we,
    input  wire [BSIZE_W-1:0]    i_cfg_data,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic                 o_found,
    output logic [SLOT_O_W-1:0]  o_slot,
    output logic [OFF_W-1:0]     o_byte_offset
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = SW + BSIZE_W;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_C1 = (CW + 1)'(CAPACITY);

    // owner store: {valid, id}; free stack of slot numbers
    logic [ID_BITS:0] r_own_mem [CAPACITY];
    logic [SW-1:0]    r_stk_mem [CAPACITY];

    logic [BSIZE_W-1:0]  r_bsize;
    logic [CW-1:0]       r_cnt;     // free slots on the stack
    logic [CW-1:0]       r_hw;      // slots ever handed out
    logic [MODE_W-1:0]   r_mode;
    logic [ID_BITS-1:0]  r_id;
    logic [CW-1:0]       r_idx;
    logic                r_rd_vld;
    logic [SW-1:0]       r_rd_idx;
    logic [ID_BITS:0]    r_own_rd;
    logic [SW-1:0]       r_stk_rd;
    logic                r_hit;
    logic [SW-1:0]       r_hit_slot;
    logic [STATUS_W-1:0] r_status;
    logic                r_found;
    logic [SW-1:0]       r_slot;
    logic [PW-1:0]       r_prod;
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_found;
    logic [SLOT_O_W-1:0] r_o_slot;
    logic [OFF_W-1:0]    r_o_off;

    logic                w_hit_now;
    logic                w_issue;
    logic                w_fresh;
    logic [SW-1:0]       w_pop_idx;
    logic [CW-1:0]       w_cnt_m1;
    logic [STATUS_W-1:0] n_status;
    logic [SW-1:0]       n_slot;
    logic [CW-1:0]       n_cnt;
    logic [CW-1:0]       n_hw;
    logic                w_own_we;
    logic [SW-1:0]       w_own_addr;
    logic [ID_BITS:0]    w_own_wdata;
    logic                w_stk_we;
    logic [SW-1:0]       w_stk_addr;
    logic [SW+SLOT_O_W-1:0] w_slot_ext;
    logic [PW+OFF_W-1:0]    w_prod_ext;

    assign w_hit_now = r_rd_vld && r_own_rd[ID_BITS] && (r_own_rd[ID_BITS-1:0] == r_id);
    assign w_issue   = i_cmd.scan_run && (r_idx < r_hw) && !w_hit_now && !r_hit;
    // the next pop comes from the untouched region when the stack is at its low mark
    assign w_fresh   = (({1'b0, r_cnt} + {1'b0, r_hw}) == CAP_C1);
    assign w_cnt_m1  = r_cnt - CW'(1);
    assign w_pop_idx = (r_cnt == '0) ? '0 : w_cnt_m1[SW-1:0];

    assign o_sts.scan_done = r_hit || ((r_idx >= r_hw) && !r_rd_vld);
    assign o_sts.out_full  = r_out_vld && i_out_stall;

    always_comb begin
        n_status    = ST_OK;
        n_slot      = '0;
        n_cnt       = r_cnt;
        n_hw        = r_hw;
        w_own_we    = 1'b0;
        w_own_addr  = r_hit_slot;
        w_own_wdata = {1'b0, r_id};
        w_stk_we    = 1'b0;
        w_stk_addr  = r_cnt[SW-1:0];
        case (r_mode)
            MODE_WRITE: begin
                if (r_cnt == '0) begin
                    n_status = ST_FULL;
                end else if (r_hit) begin
                    n_status = ST_PRESENT;
                end else begin
                    n_slot = w_fresh ? r_hw[SW-1:0] : r_stk_rd;
                    n_cnt  = w_cnt_m1;
                    if (w_fresh) begin
                        n_hw = r_hw + CW'(1);
                    end
                    w_own_we    = 1'b1;
                    w_own_addr  = n_slot;
                    w_own_wdata = {1'b1, r_id};
                end
            end
            MODE_READ, MODE_CONTAINS: begin
                if (r_hit) begin
                    n_slot = r_hit_slot;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_EVICT: begin
                if (r_hit) begin
                    n_slot   = r_hit_slot;
                    w_own_we = 1'b1;
                    if (r_cnt < CAP_C) begin
                        w_stk_we = 1'b1;
                        n_cnt    = r_cnt + CW'(1);
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_own_we) begin
            r_own_mem[w_own_addr] <= w_own_wdata;
        end
        if (w_issue) begin
            r_own_rd <= r_own_mem[r_idx[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_stk_we) begin
            r_stk_mem[w_stk_addr] <= r_hit_slot;
        end
        r_stk_rd <= r_stk_mem[w_pop_idx];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize   <= BSIZE_RESET;
            r_cnt     <= CAP_C;
            r_hw      <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bsize <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_hit    <= 1'b0;
            end else begin
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (w_hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.exec) begin
                r_cnt <= n_cnt;
                r_hw  <= n_hw;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign w_slot_ext = {{SLOT_O_W{1'b0}}, r_slot};
    assign w_prod_ext = {{OFF_W{1'b0}}, r_prod};

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_mode;
            r_id   <= i_block_id[ID_BITS-1:0];
        end
        if (w_issue) begin
            r_rd_idx <= r_idx[SW-1:0];
        end
        if (w_hit_now && !i_cmd.start) begin
            r_hit_slot <= r_rd_idx;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_found  <= r_hit;
            r_slot   <= n_slot;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_slot) * PW'(r_bsize);
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_slot   <= w_slot_ext[SLOT_O_W-1:0];
            r_o_off    <= w_prod_ext[OFF_W-1:0];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_slot        = r_o_slot;
    assign o_byte_offset = r_o_off;

endmodule : bsa_datapath
`default_nettype wire
